### rtl/core/uks_pkg.sv
// shared types, codes and defaults for the unique key stack
package uks_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_KEY_BYTES   = 8;

    localparam int KEY_W   = 64;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   top_key;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic pop_rd;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/uks_ram.sv
// generic single write port ram with registered read
module uks_ram #(
    parameter int   WIDTH = 64,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/uks_ctrl.sv
// sequencing state machine for the unique key stack
module uks_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [uks_pkg::MODE_W-1:0] i_mode,
    output logic                  o_in_ready,
    input  uks_pkg::t_sts         i_sts,
    output uks_pkg::t_cmd         o_cmd
);
    import uks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_POP    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_mode == MODE_PUSH) begin
                        n_state = S_SCAN;
                    end else if (i_mode == MODE_POP && !i_sts.empty) begin
                        n_state = S_POP;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_POP: begin
                // fetch the entry that becomes the new top
                o_cmd.pop_rd = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/uks_dp.sv
// datapath: key store, duplicate scan, count, top key and result register
module uks_dp #(
    parameter int STACK_DEPTH = uks_pkg::DEF_STACK_DEPTH,
    parameter int KEY_BYTES   = uks_pkg::DEF_KEY_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uks_pkg::t_in  i_in,
    input  uks_pkg::t_cmd i_cmd,
    output uks_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uks_pkg::t_out o_out
);
    import uks_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // keep bytes up to the first zero byte and below the key length
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             alive;
        logic [7:0]       b;
        res   = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            b = raw[8*i +: 8];
            if (alive && (i < KEY_BYTES) && (b != 8'd0)) begin
                res[8*i +: 8] = b;
            end else begin
                alive = 1'b0;
            end
        end
        return res;
    endfunction

    logic [KEY_W-1:0]  r_key,  n_key;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [CW-1:0]     r_idx,  n_idx;
    logic              r_pend, n_pend;
    logic              r_hit,  n_hit;
    logic [CW-1:0]     r_count, n_count;
    logic [KEY_W-1:0]  r_top,  n_top;
    logic              r_out_valid, n_out_valid;
    t_out              r_out,  n_out;

    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    logic [KEY_W-1:0]  w_rdata;
    logic [CW-1:0]     w_cnt_m2;
    logic [CW+4:0]     w_cnt_ext;
    logic [STAT_W-1:0] w_status;

    uks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cnt_m2  = r_count - CW'(2);
    assign w_cnt_ext = {5'b0, n_count};

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_done = !r_pend && (r_hit || (r_idx == r_count));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_key       = r_key;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_count     = r_count;
        n_top       = r_top;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_re        = 1'b0;
        w_raddr     = r_idx[AW-1:0];
        w_we        = 1'b0;
        w_status    = ST_OK;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_key  = norm_key(i_in.key);
            n_mode = i_in.mode;
            n_idx  = '0;
            n_pend = 1'b0;
            n_hit  = 1'b0;
        end

        if (i_cmd.scan) begin
            // one read issued per cycle, compared the cycle after
            if (r_pend && (w_rdata == r_key)) begin
                n_hit = 1'b1;
            end
            if ((r_idx < r_count) && !r_hit) begin
                w_re   = 1'b1;
                n_idx  = r_idx + CW'(1);
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
        end

        if (i_cmd.pop_rd) begin
            w_re    = 1'b1;
            w_raddr = w_cnt_m2[AW-1:0];
        end

        if (i_cmd.commit) begin
            unique case (r_mode)
                MODE_PUSH: begin
                    if (r_hit) begin
                        w_status = ST_DUP;
                    end else if (r_count >= CW'(STACK_DEPTH)) begin
                        w_status = ST_FULL;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        n_top   = r_key;
                    end
                end
                MODE_POP: begin
                    if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_top   = (r_count == CW'(1)) ? '0 : w_rdata;
                    end
                end
                default: begin
                    // peek and the unused code
                    if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end
                end
            endcase
            n_out_valid       = 1'b1;
            n_out.status      = w_status;
            n_out.top_key     = n_top;
            n_out.entry_count = w_cnt_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_mode <= n_mode;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/unique_key_stack_unit.sv
// top level of the unique key stack: controller, datapath and key store
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    i_in  (mode, key)
//   result    out        o_out_valid / i_out_ready  o_out (status, top_key, entry_count)
//
// a push steps through load, a scan that reads stored entries one at a time
// through the single read port of the key store and checks each against the
// key, and commit; the scan stops early on a duplicate. a pop steps through
// load, a read of the new top and commit; peek and empty pop: load, commit.
// reset is synchronous, active low; it clears the count, the top key and the
// control state; the key store is not cleared and needs no clearing pass.
// a result waits in the output register while the next request is accepted;
// commit of the following one stalls until that register is taken.
module unique_key_stack_unit #(
    parameter int STACK_DEPTH = uks_pkg::DEF_STACK_DEPTH,
    parameter int KEY_BYTES   = uks_pkg::DEF_KEY_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  uks_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uks_pkg::t_out o_out
);
    import uks_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    uks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in.mode),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    uks_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
